/* rtl/tri_pkg.sv */
// ----------------------------------------------------------------------------
// tri_pkg: shared widths and types for the trilateration solver
// Field widths, arithmetic widths and the control word passed between stages.
// ----------------------------------------------------------------------------
package tri_pkg;
   localparam int CoordWidth  = 24;
   localparam int RangeWidth  = 23;
   localparam int PosWidth    = 32;
   localparam int CfgWidth    = 32;
   localparam int DefFracBits = 8;
   localparam int DiffWidth   = 25;  // coordinate difference
   localparam int KWidth      = 50;  // k = x*x + y*y - r*r
   localparam int DkWidth     = 51;  // difference of k
   localparam int DetWidth    = 51;  // determinant
   localparam int NumWidth    = 78;  // numerator
   localparam int DenWidth    = 52;  // 2 * |det|
   localparam int QuoWidth    = 78;  // unsigned quotient

   typedef struct packed {
      logic valid;
      logic degen;
      logic neg_x;
      logic neg_y;
   } ctl_type;
endpackage

/* rtl/tri_if.sv */
// ----------------------------------------------------------------------------
// tri_req_if / tri_rsp_if: valid-ready channels of the solver
// Request carries three beacons, response carries the position fix.
// ----------------------------------------------------------------------------
interface tri_req_if;
   import tri_pkg::*;
   logic valid;
   logic ready;
   logic signed [CoordWidth-1:0] beacon0_x, beacon0_y, beacon1_x, beacon1_y;
   logic signed [CoordWidth-1:0] beacon2_x, beacon2_y;
   logic [RangeWidth-1:0] beacon0_range, beacon1_range, beacon2_range;
   modport source (output valid, beacon0_x, beacon0_y, beacon0_range, beacon1_x,
                   beacon1_y, beacon1_range, beacon2_x, beacon2_y, beacon2_range,
                   input ready);
   modport sink (input valid, beacon0_x, beacon0_y, beacon0_range, beacon1_x,
                 beacon1_y, beacon1_range, beacon2_x, beacon2_y, beacon2_range,
                 output ready);
endinterface

interface tri_rsp_if;
   import tri_pkg::*;
   logic valid;
   logic ready;
   logic signed [PosWidth-1:0] pos_x, pos_y;
   logic degenerate;
   modport source (output valid, pos_x, pos_y, degenerate, input ready);
   modport sink (input valid, pos_x, pos_y, degenerate, output ready);
endinterface

/* rtl/trilateration_three_beacons.sv */
// ----------------------------------------------------------------------------
// trilateration_three_beacons: radical-center position fix from three beacons
// ----------------------------------------------------------------------------
// Usage: present three beacon positions and ranges on the req channel as one
// word; the fix leaves on the rsp channel as one word (pos_x, pos_y,
// degenerate). Coordinates carry DefFracBits fraction bits both ways; the
// arithmetic is exact but for the truncating divide, so the fraction width
// never enters the datapath. Throughput: one word per cycle while rsp is not
// stalled. Pipeline: 4 front stages (squares, determinant, partial products,
// combine), 78 divider stages (one quotient bit each), one saturation stage:
// 83 register stages in all.
// The whole pipe advances as one shift line whenever its last stage is empty
// or being taken, so a stall at rsp freezes every stage and drops nothing.
// req_ready follows that advance signal.
// Reset (synchronous) empties the pipe and sets csr min_determinant to 1.
// Write csr only while the pipe is idle. When |det| is below min_determinant,
// or zero, the word reports degenerate with zero coordinates.
// ----------------------------------------------------------------------------
module trilateration_three_beacons (
   input  logic                          clock,
   input  logic                          reset,
   tri_req_if.sink                       req,
   tri_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [tri_pkg::CfgWidth-1:0]  csr_wdata
);
   import tri_pkg::*;

   // threshold register
   logic [CfgWidth-1:0] min_det_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_det_ff <= CfgWidth'(1);
      end else if (csr_we) begin
         min_det_ff <= csr_wdata;
      end
   end

   // advance whenever the output slot is free or being drained
   logic advance;
   logic out_valid_ff;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   logic signed [CoordWidth-1:0] bx [3], by [3];
   logic [RangeWidth-1:0] br [3];
   always_comb begin
      bx[0] = req.beacon0_x; by[0] = req.beacon0_y; br[0] = req.beacon0_range;
      bx[1] = req.beacon1_x; by[1] = req.beacon1_y; br[1] = req.beacon1_range;
      bx[2] = req.beacon2_x; by[2] = req.beacon2_y; br[2] = req.beacon2_range;
   end

   ctl_type front_ctl, div_ctl;
   logic [NumWidth-1:0] num_x, num_y;
   logic [DenWidth-1:0] den;
   logic [QuoWidth-1:0] quo_x, quo_y;

   tri_front u_front (
      .clock, .reset, .advance,
      .valid_in (req.valid),
      .min_det  (min_det_ff),
      .bx, .by, .br,
      .ctl_out  (front_ctl),
      .num_x, .num_y, .den
   );

   tri_divider u_div (
      .clock, .reset, .advance,
      .ctl_in   (front_ctl),
      .num_x_in (num_x),
      .num_y_in (num_y),
      .den_in   (den),
      .ctl_out  (div_ctl),
      .quo_x, .quo_y
   );

   // saturate a magnitude with its sign to the output range
   function automatic logic [PosWidth-1:0] sat(input logic [QuoWidth-1:0] q,
                                               input logic neg);
      logic big;
      big = q[QuoWidth-1:PosWidth-1] != '0;
      if (neg) begin
         if (big && q != (QuoWidth'(1) << (PosWidth-1))) sat = {1'b1, {PosWidth-1{1'b0}}};
         else sat = PosWidth'(-q);
      end else begin
         sat = big ? {1'b0, {PosWidth-1{1'b1}}} : PosWidth'(q);
      end
   endfunction

   logic [PosWidth-1:0] pos_x_ff, pos_y_ff;
   logic degen_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_ctl.valid;
      end
      if (advance) begin
         // hold zero coordinates on a degenerate fix
         pos_x_ff <= div_ctl.degen ? '0 : sat(quo_x, div_ctl.neg_x);
         pos_y_ff <= div_ctl.degen ? '0 : sat(quo_y, div_ctl.neg_y);
         degen_ff <= div_ctl.degen;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.pos_x      = pos_x_ff;
   assign rsp.pos_y      = pos_y_ff;
   assign rsp.degenerate = degen_ff;

   // a stalled word holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.pos_x) && $stable(rsp.pos_y))
      else $error("stalled word changed");
   // a degenerate word carries zero coordinates
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.degenerate |-> rsp.pos_x == '0 && rsp.pos_y == '0)
      else $error("degenerate word has coordinates");
   // input is taken exactly when the pipe advances
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("ready mismatch");
endmodule

/* rtl/tri_divider.sv */
// ----------------------------------------------------------------------------
// tri_divider: pipelined restoring divider, one quotient bit per stage
// Unsigned numerator over unsigned denominator, control word travels along.
// ----------------------------------------------------------------------------
module tri_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  tri_pkg::ctl_type            ctl_in,
   input  logic [tri_pkg::NumWidth-1:0] num_x_in,
   input  logic [tri_pkg::NumWidth-1:0] num_y_in,
   input  logic [tri_pkg::DenWidth-1:0] den_in,
   output tri_pkg::ctl_type            ctl_out,
   output logic [tri_pkg::QuoWidth-1:0] quo_x,
   output logic [tri_pkg::QuoWidth-1:0] quo_y
);
   import tri_pkg::*;
   localparam int N = NumWidth;
   localparam int RW = DenWidth + 1;

   ctl_type             ctl_ff [N+1];
   logic [N-1:0]        nx_ff [N+1];
   logic [N-1:0]        ny_ff [N+1];
   logic [RW-1:0]       rx_ff [N+1];
   logic [RW-1:0]       ry_ff [N+1];
   logic [DenWidth-1:0] d_ff  [N+1];

   always_comb begin
      ctl_ff[0] = ctl_in;
      nx_ff[0]  = num_x_in;
      ny_ff[0]  = num_y_in;
      rx_ff[0]  = '0;
      ry_ff[0]  = '0;
      d_ff[0]   = den_in;
   end

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [RW-1:0] tx_in, ty_in;
      logic          gx, gy;
      always_comb begin
         tx_in = {rx_ff[s][RW-2:0], nx_ff[s][N-1]};
         ty_in = {ry_ff[s][RW-2:0], ny_ff[s][N-1]};
         gx = tx_in >= {1'b0, d_ff[s]};
         gy = ty_in >= {1'b0, d_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1].valid <= 1'b0;
         end else if (advance) begin
            ctl_ff[s+1].valid <= ctl_ff[s].valid;
         end
         if (advance) begin
            ctl_ff[s+1].degen <= ctl_ff[s].degen;
            ctl_ff[s+1].neg_x <= ctl_ff[s].neg_x;
            ctl_ff[s+1].neg_y <= ctl_ff[s].neg_y;
            d_ff[s+1]  <= d_ff[s];
            rx_ff[s+1] <= gx ? tx_in - {1'b0, d_ff[s]} : tx_in;
            ry_ff[s+1] <= gy ? ty_in - {1'b0, d_ff[s]} : ty_in;
            nx_ff[s+1] <= {nx_ff[s][N-2:0], gx};
            ny_ff[s+1] <= {ny_ff[s][N-2:0], gy};
         end
      end
   end

   assign ctl_out = ctl_ff[N];
   assign quo_x   = nx_ff[N];
   assign quo_y   = ny_ff[N];
endmodule

/* rtl/tri_front.sv */
// ----------------------------------------------------------------------------
// tri_front: squares, differences, determinant and numerators
// Four register stages; numerator products are cut into 25x25 partial products.
// ----------------------------------------------------------------------------
module tri_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          valid_in,
   input  logic [tri_pkg::CfgWidth-1:0]  min_det,
   input  logic signed [tri_pkg::CoordWidth-1:0] bx [3],
   input  logic signed [tri_pkg::CoordWidth-1:0] by [3],
   input  logic [tri_pkg::RangeWidth-1:0] br [3],
   output tri_pkg::ctl_type              ctl_out,
   output logic [tri_pkg::NumWidth-1:0]  num_x,
   output logic [tri_pkg::NumWidth-1:0]  num_y,
   output logic [tri_pkg::DenWidth-1:0]  den
);
   import tri_pkg::*;
   localparam int MagWidth = DkWidth - 1;

   // stage 1: squares and coordinate differences
   logic [2:0] v_ff;
   logic signed [2*CoordWidth-1:0] sq_x [3], sq_y [3];
   logic [2*RangeWidth-1:0]        sq_r [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_x[i] = bx[i] * bx[i];
         sq_y[i] = by[i] * by[i];
         sq_r[i] = br[i] * br[i];
      end
   end
   logic signed [KWidth-1:0]    k_ff [3];
   logic signed [DiffWidth-1:0] dx01_ff, dx12_ff, dy01_ff, dy12_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            k_ff[i] <= KWidth'(sq_x[i]) + KWidth'(sq_y[i]) - KWidth'(sq_r[i]);
         end
         dx01_ff <= DiffWidth'(bx[0]) - DiffWidth'(bx[1]);
         dx12_ff <= DiffWidth'(bx[1]) - DiffWidth'(bx[2]);
         dy01_ff <= DiffWidth'(by[0]) - DiffWidth'(by[1]);
         dy12_ff <= DiffWidth'(by[1]) - DiffWidth'(by[2]);
      end
   end

   // stage 2: k differences, determinant
   logic signed [2*DiffWidth-1:0] pd_a, pd_b;
   always_comb begin
      pd_a = dx01_ff * dy12_ff;
      pd_b = dy01_ff * dx12_ff;
   end
   logic signed [DkWidth-1:0]   dk01_ff, dk12_ff;
   logic signed [DetWidth-1:0]  det_ff;
   logic signed [DiffWidth-1:0] dx01_b_ff, dx12_b_ff, dy01_b_ff, dy12_b_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dk01_ff <= DkWidth'(k_ff[0]) - DkWidth'(k_ff[1]);
         dk12_ff <= DkWidth'(k_ff[1]) - DkWidth'(k_ff[2]);
         det_ff  <= DetWidth'(pd_a) - DetWidth'(pd_b);
         dx01_b_ff <= dx01_ff; dx12_b_ff <= dx12_ff;
         dy01_b_ff <= dy01_ff; dy12_b_ff <= dy12_ff;
      end
   end

   // stage 3: partial products on magnitude halves of dk (25 x 25)
   localparam int H = MagWidth / 2;
   localparam int PW = H + DiffWidth;
   logic [MagWidth-1:0] mk01, mk12;
   logic [DiffWidth-1:0] mdx01, mdx12, mdy01, mdy12;
   logic [PW-1:0] pp_lo [4], pp_hi [4];
   always_comb begin
      mk01  = MagWidth'(dk01_ff[DkWidth-1] ? -dk01_ff : dk01_ff);
      mk12  = MagWidth'(dk12_ff[DkWidth-1] ? -dk12_ff : dk12_ff);
      mdx01 = dx01_b_ff[DiffWidth-1] ? -dx01_b_ff : dx01_b_ff;
      mdx12 = dx12_b_ff[DiffWidth-1] ? -dx12_b_ff : dx12_b_ff;
      mdy01 = dy01_b_ff[DiffWidth-1] ? -dy01_b_ff : dy01_b_ff;
      mdy12 = dy12_b_ff[DiffWidth-1] ? -dy12_b_ff : dy12_b_ff;
      // nx = dk01*dy12 - dy01*dk12 ; ny = dx01*dk12 - dk01*dx12
      pp_lo[0] = mk01[H-1:0] * mdy12;
      pp_hi[0] = mk01[MagWidth-1:H] * mdy12;
      pp_lo[1] = mk12[H-1:0] * mdy01;
      pp_hi[1] = mk12[MagWidth-1:H] * mdy01;
      pp_lo[2] = mk12[H-1:0] * mdx01;
      pp_hi[2] = mk12[MagWidth-1:H] * mdx01;
      pp_lo[3] = mk01[H-1:0] * mdx12;
      pp_hi[3] = mk01[MagWidth-1:H] * mdx12;
   end
   logic [PW-1:0] p_lo_ff [4], p_hi_ff [4];
   logic          s_ff [4];
   logic signed [DetWidth-1:0] det3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            p_lo_ff[i] <= pp_lo[i];
            p_hi_ff[i] <= pp_hi[i];
         end
         s_ff[0]    <= dk01_ff[DkWidth-1] ^ dy12_b_ff[DiffWidth-1];
         s_ff[1]    <= dk12_ff[DkWidth-1] ^ dy01_b_ff[DiffWidth-1];
         s_ff[2]    <= dk12_ff[DkWidth-1] ^ dx01_b_ff[DiffWidth-1];
         s_ff[3]    <= dk01_ff[DkWidth-1] ^ dx12_b_ff[DiffWidth-1];
         det3_ff    <= det_ff;
      end
   end

   // stage 4: combine, sign, degenerate test
   logic signed [NumWidth-1:0] t_in [4];
   logic signed [NumWidth-1:0] nx_sv, ny_sv;
   logic [DetWidth-1:0] mdet;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         t_in[i] = $signed((NumWidth'(p_hi_ff[i]) << H) + NumWidth'(p_lo_ff[i]));
         if (s_ff[i]) t_in[i] = -t_in[i];
      end
      nx_sv = t_in[0] - t_in[1];
      ny_sv = t_in[2] - t_in[3];
      mdet  = det3_ff[DetWidth-1] ? DetWidth'(-det3_ff) : DetWidth'(det3_ff);
   end
   ctl_type ctl_ff;
   logic [NumWidth-1:0] nx_ff, ny_ff;
   logic [DenWidth-1:0] den_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         v_ff         <= {v_ff[1:0], valid_in};
         ctl_ff.valid <= v_ff[2];
      end
      if (advance) begin
         nx_ff  <= nx_sv[NumWidth-1] ? NumWidth'(-nx_sv) : NumWidth'(nx_sv);
         ny_ff  <= ny_sv[NumWidth-1] ? NumWidth'(-ny_sv) : NumWidth'(ny_sv);
         den_ff <= {mdet, 1'b0};
         ctl_ff.degen <= (mdet == '0) || (mdet < DetWidth'(min_det));
         ctl_ff.neg_x <= nx_sv[NumWidth-1] ^ det3_ff[DetWidth-1];
         ctl_ff.neg_y <= ny_sv[NumWidth-1] ^ det3_ff[DetWidth-1];
      end
   end
   assign ctl_out = ctl_ff;
   assign num_x   = nx_ff;
   assign num_y   = ny_ff;
   assign den     = ctl_ff.degen ? DenWidth'(1) : den_ff;
endmodule
